### rtl/kct_pkg.sv
`timescale 1ns / 1ps

package kct_pkg;

  localparam int ROWS_DEF      = 4;
  localparam int SLOTS_DEF     = 8;
  localparam int KEY_CHARS_DEF = 8;

  localparam int KEY_FW    = 64;
  localparam int COUNT_W   = 16;
  localparam int STATUS_W  = 3;
  localparam int ROW_FW    = 2;
  localparam int SLOT_FW   = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic MODE_INC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW  = 3'd0,
    ST_INC  = 3'd1,
    ST_FULL = 3'd2,
    ST_DEC  = 3'd3,
    ST_MISS = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_t;

endpackage

### rtl/kct_req_if.sv
`timescale 1ns / 1ps

interface kct_req_if import kct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [KEY_FW-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

### rtl/kct_rsp_if.sv
`timescale 1ns / 1ps

interface kct_rsp_if import kct_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [ROW_FW-1:0]  row;
  logic [SLOT_FW-1:0] slot;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output status, output row, output slot, output count,
                  input ready);
  modport sink   (input valid, input status, input row, input slot, input count,
                  output ready);
endinterface

### rtl/keyed_count_table_unit.sv
`timescale 1ns / 1ps

// Search: a key that sits at entry i (row-major) is found when the scan reaches entry i;
// a miss or a fresh insert scans the whole table.
// Throughput: one item at a time; ready returns the cycle after the result is taken.
// The scan runs one entry per cycle through a single key compare on the table memory port.
// Reset: a pass over all ROWS*SLOTS entries clears the valid marks; no item is taken meanwhile.
module keyed_count_table_unit import kct_pkg::*; #(
  parameter int ROWS      = ROWS_DEF,
  parameter int SLOTS     = SLOTS_DEF,
  parameter int KEY_CHARS = KEY_CHARS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  kct_req_if.sink          req,
  kct_rsp_if.source        rsp
);

  localparam int ENTRIES = ROWS * SLOTS;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W   = 8 * KEY_CHARS;
  localparam int META_W  = COUNT_W + 1;

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(ENTRIES - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  // meta word: {valid, count}
  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [META_W-1:0] meta_mem [ENTRIES];

  state_t state, state_next;

  logic [IDX_W-1:0]   iss_idx;
  logic [ROW_W-1:0]   iss_row;
  logic [SLOT_W-1:0]  iss_slot;
  logic               iss_done;

  logic               cmp_vld;
  logic               cmp_last;
  logic [IDX_W-1:0]   cmp_idx;
  logic [ROW_W-1:0]   cmp_row;
  logic [SLOT_W-1:0]  cmp_slot;

  logic [KEY_W-1:0]   rd_key;
  logic [META_W-1:0]  rd_meta;

  logic               op_mode;
  logic [KEY_W-1:0]   op_key;

  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [ROW_W-1:0]   hit_row;
  logic [SLOT_W-1:0]  hit_slot;
  logic [COUNT_W-1:0] hit_cnt;

  logic               free_ok;
  logic [IDX_W-1:0]   free_idx;
  logic [ROW_W-1:0]   free_row;
  logic [SLOT_W-1:0]  free_slot;

  status_t            res_status, res_status_next;
  logic [ROW_FW-1:0]  res_row, res_row_next;
  logic [SLOT_FW-1:0] res_slot, res_slot_next;
  logic [COUNT_W-1:0] res_count, res_count_next;

  logic               match;
  logic               is_free;
  logic               key_we;
  logic               meta_we;
  logic [IDX_W-1:0]   wr_idx;
  logic [META_W-1:0]  wr_meta;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] cnt_dec;

  assign match   = cmp_vld && rd_meta[COUNT_W] && (rd_key == op_key);
  assign is_free = cmp_vld && !rd_meta[COUNT_W];

  assign cnt_inc = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + COUNT_W'(1);
  assign cnt_dec = (hit_cnt != '0) ? hit_cnt - COUNT_W'(1) : '0;

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = (state == S_DONE);
  assign rsp.status = res_status;
  assign rsp.row    = res_row;
  assign rsp.slot   = res_slot;
  assign rsp.count  = res_count;

  always_comb begin
    state_next      = state;
    key_we          = 1'b0;
    meta_we         = 1'b0;
    wr_idx          = iss_idx;
    wr_meta         = '0;
    res_status_next = res_status;
    res_row_next    = res_row;
    res_slot_next   = res_slot;
    res_count_next  = res_count;
    case (state)
      S_CLEAR: begin
        meta_we = 1'b1;
        if (iss_idx == IDX_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (match || (cmp_vld && cmp_last)) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_DONE;
        if (hit) begin
          meta_we       = 1'b1;
          wr_idx        = hit_idx;
          res_row_next  = ROW_FW'(hit_row);
          res_slot_next = SLOT_FW'(hit_slot);
          if (op_mode == MODE_DEC) begin
            wr_meta         = {(cnt_dec != '0), cnt_dec};
            res_status_next = ST_DEC;
            res_count_next  = cnt_dec;
          end else begin
            wr_meta         = {1'b1, cnt_inc};
            res_status_next = ST_INC;
            res_count_next  = cnt_inc;
          end
        end else if (op_mode == MODE_INC && free_ok) begin
          key_we          = 1'b1;
          meta_we         = 1'b1;
          wr_idx          = free_idx;
          wr_meta         = {1'b1, COUNT_W'(1)};
          res_status_next = ST_NEW;
          res_row_next    = ROW_FW'(free_row);
          res_slot_next   = SLOT_FW'(free_slot);
          res_count_next  = COUNT_W'(1);
        end else begin
          res_status_next = (op_mode == MODE_DEC) ? ST_MISS : ST_FULL;
          res_row_next    = '0;
          res_slot_next   = '0;
          res_count_next  = '0;
        end
      end
      S_DONE: begin
        if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // table memory: one read port for the scan, one write port
  always_ff @(posedge clk) begin
    rd_key  <= key_mem[iss_idx];
    rd_meta <= meta_mem[iss_idx];
    if (key_we) begin
      key_mem[wr_idx] <= op_key;
    end
    if (meta_we) begin
      meta_mem[wr_idx] <= wr_meta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_idx  <= '0;
      iss_row  <= '0;
      iss_slot <= '0;
      iss_done <= 1'b0;
      cmp_vld  <= 1'b0;
      cmp_last <= 1'b0;
      hit      <= 1'b0;
      free_ok  <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (iss_idx != IDX_LAST) begin
            iss_idx <= iss_idx + IDX_W'(1);
          end
        end
        S_IDLE: begin
          iss_idx  <= '0;
          iss_row  <= '0;
          iss_slot <= '0;
          iss_done <= 1'b0;
          cmp_vld  <= 1'b0;
          cmp_last <= 1'b0;
          hit      <= 1'b0;
          free_ok  <= 1'b0;
        end
        S_SCAN: begin
          // advance the read pointer; the compare trails it through the registered read
          cmp_vld  <= !iss_done;
          cmp_last <= (iss_idx == IDX_LAST);
          if (!iss_done) begin
            if (iss_idx == IDX_LAST) begin
              iss_done <= 1'b1;
            end else begin
              iss_idx <= iss_idx + IDX_W'(1);
              if (iss_slot == SLOT_LAST) begin
                iss_slot <= '0;
                iss_row  <= iss_row + ROW_W'(1);
              end else begin
                iss_slot <= iss_slot + SLOT_W'(1);
              end
            end
          end
          if (match) begin
            hit <= 1'b1;
          end
          if (is_free && !free_ok) begin
            free_ok <= 1'b1;
          end
        end
        default: begin
          cmp_vld <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op_mode <= req.mode;
      op_key  <= req.key[KEY_W-1:0];
    end
    if (state == S_SCAN) begin
      cmp_idx  <= iss_idx;
      cmp_row  <= iss_row;
      cmp_slot <= iss_slot;
    end
    if (state == S_SCAN && match) begin
      hit_idx  <= cmp_idx;
      hit_row  <= cmp_row;
      hit_slot <= cmp_slot;
      hit_cnt  <= rd_meta[COUNT_W-1:0];
    end
    if (state == S_SCAN && is_free && !free_ok) begin
      free_idx  <= cmp_idx;
      free_row  <= cmp_row;
      free_slot <= cmp_slot;
    end
    res_status <= res_status_next;
    res_row    <= res_row_next;
    res_slot   <= res_slot_next;
    res_count  <= res_count_next;
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import kct_pkg::*;

  localparam int ROWS      = ROWS_DEF;
  localparam int SLOTS     = SLOTS_DEF;
  localparam int KEY_CHARS = KEY_CHARS_DEF;
  localparam int ENTRIES   = ROWS * SLOTS;
  localparam logic [KEY_FW-1:0] KEY_MASK = {KEY_FW{1'b1}} >> (8 * (8 - KEY_CHARS));
  localparam int POOL_N    = 40;
  localparam int PHASE_OPS = 440;
  localparam int SETTLE    = ENTRIES + 8;
  localparam longint LIMIT = 500_000;

  typedef struct packed {
    status_t            status;
    logic [ROW_FW-1:0]  row;
    logic [SLOT_FW-1:0] slot;
    logic [COUNT_W-1:0] count;
  } tally_t;

  typedef struct {
    logic              mode;
    logic [KEY_FW-1:0] key;
    int                idle_pct;
    int                stall_pct;
    bit                drain;
  } table_op_t;

  logic clk;
  logic rst;

  kct_req_if req_ch ();
  kct_rsp_if rsp_ch ();

  keyed_count_table_unit #(
    .ROWS      (ROWS),
    .SLOTS     (SLOTS),
    .KEY_CHARS (KEY_CHARS)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the table
  logic               tbl_valid [ENTRIES];
  logic [KEY_FW-1:0]  tbl_key   [ENTRIES];
  logic [COUNT_W-1:0] tbl_count [ENTRIES];

  table_op_t op_q[$];
  tally_t    tally_q[$];
  int        cur_idle;
  int        cur_stall;
  int        stall_pct;
  int        err_cnt;
  longint    cycles;
  logic [KEY_FW-1:0] key_pool [POOL_N];
  logic [KEY_FW-1:0] fill_keys [ENTRIES];

  function automatic tally_t tally_apply(logic mode, logic [KEY_FW-1:0] raw_key);
    logic [KEY_FW-1:0] k;
    int                hit;
    int                idx;
    status_t           st;
    tally_t            r;
    k   = raw_key & KEY_MASK;
    hit = -1;
    idx = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && tbl_valid[i] && tbl_key[i] == k) hit = i;
    if (mode == MODE_INC) begin
      if (hit >= 0) begin
        if (tbl_count[hit] != COUNT_MAX) tbl_count[hit] = tbl_count[hit] + 1'b1;
        st  = ST_INC;
        idx = hit;
      end else begin
        for (int i = 0; i < ENTRIES; i++)
          if (idx < 0 && !tbl_valid[i]) idx = i;
        if (idx < 0) begin
          st = ST_FULL;
        end else begin
          tbl_valid[idx] = 1'b1;
          tbl_key[idx]   = k;
          tbl_count[idx] = COUNT_W'(1);
          st = ST_NEW;
        end
      end
    end else begin
      if (hit < 0) begin
        st = ST_MISS;
      end else begin
        if (tbl_count[hit] != 0) tbl_count[hit] = tbl_count[hit] - 1'b1;
        if (tbl_count[hit] == 0) tbl_valid[hit] = 1'b0;
        st  = ST_DEC;
        idx = hit;
      end
    end
    r = '0;
    r.status = st;
    if (idx >= 0) begin
      r.row   = ROW_FW'(idx / SLOTS);
      r.slot  = SLOT_FW'(idx % SLOTS);
      r.count = tbl_count[idx];
    end
    return r;
  endfunction

  task automatic queue_op(logic mode, logic [KEY_FW-1:0] key, bit drain = 1'b0);
    table_op_t op;
    op.mode      = mode;
    op.key       = key;
    op.idle_pct  = cur_idle;
    op.stall_pct = cur_stall;
    op.drain     = drain;
    op_q.push_back(op);
  endtask

  task automatic flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Driver
  always @(posedge clk) begin : drive
    logic      free;
    logic      go;
    table_op_t op;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      free = !req_ch.valid || req_ch.ready;
      if (req_ch.valid && req_ch.ready) tally_q.push_back(tally_apply(req_ch.mode, req_ch.key));
      if (free) begin
        go = op_q.size() > 0;
        // hold a draining item until every result is back
        if (go && op_q[0].drain && tally_q.size() > 0) go = 1'b0;
        if (go && $urandom_range(99) < op_q[0].idle_pct) go = 1'b0;
        if (go) begin
          op = op_q.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.mode  <= op.mode;
          req_ch.key   <= op.key;
          stall_pct    <= op.stall_pct;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin : watch
    tally_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (tally_q.size() == 0) begin
          flag_error($sformatf("unexpected result: status %0d row %0d slot %0d count %0d",
                               rsp_ch.status, rsp_ch.row, rsp_ch.slot, rsp_ch.count));
        end else begin
          want = tally_q.pop_front();
          if (want.status != rsp_ch.status || want.row != rsp_ch.row ||
              want.slot != rsp_ch.slot || want.count != rsp_ch.count)
            flag_error($sformatf(
              "mismatch: exp status %0d row %0d slot %0d count %0d, got %0d %0d %0d %0d",
              want.status, want.row, want.slot, want.count,
              rsp_ch.status, rsp_ch.row, rsp_ch.slot, rsp_ch.count));
        end
      end
    end
  end

  initial begin
    int ins_pct;
    logic [KEY_FW-1:0] k;
    clk          = 1'b0;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_INC;
    req_ch.key   = '0;
    rsp_ch.ready = 1'b0;
    stall_pct    = 0;
    cycles       = 0;
    err_cnt      = 0;
    cur_idle     = 0;
    cur_stall    = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_count[i] = '0;
    end

    // Directed: zero key, all-ones key, freeing and reuse of an entry
    queue_op(MODE_DEC, 64'h0);
    queue_op(MODE_INC, 64'h0);
    queue_op(MODE_INC, 64'h0);
    queue_op(MODE_INC, {KEY_FW{1'b1}});
    queue_op(MODE_INC, 64'h41);
    queue_op(MODE_INC, 64'h4847_4645_4443_4241);
    queue_op(MODE_DEC, {KEY_FW{1'b1}});
    queue_op(MODE_DEC, {KEY_FW{1'b1}});
    queue_op(MODE_INC, 64'h8000_0000_0000_0000);
    queue_op(MODE_DEC, 64'h0);
    queue_op(MODE_DEC, 64'h0);
    queue_op(MODE_DEC, 64'h41);
    queue_op(MODE_DEC, 64'h4847_4645_4443_4241);
    queue_op(MODE_DEC, 64'h8000_0000_0000_0000);

    // Fill the table, overflow it, then empty it again
    for (int i = 0; i < ENTRIES; i++) begin
      fill_keys[i] = {$urandom, $urandom};
      queue_op(MODE_INC, fill_keys[i], i == 0);
    end
    queue_op(MODE_INC, {$urandom, $urandom});
    queue_op(MODE_INC, {$urandom, $urandom});
    queue_op(MODE_INC, fill_keys[ENTRIES-1]);
    queue_op(MODE_DEC, {$urandom, $urandom});
    queue_op(MODE_DEC, fill_keys[ENTRIES-1]);
    for (int i = 0; i < ENTRIES; i++) queue_op(MODE_DEC, fill_keys[i]);

    // Count one key up, then down until its entry is freed and it misses
    queue_op(MODE_INC, 64'h5a5a_5a5a_5a5a_5a5a, 1'b1);
    for (int i = 0; i < 6; i++) queue_op(MODE_INC, 64'h5a5a_5a5a_5a5a_5a5a);
    for (int i = 0; i < 8; i++) queue_op(MODE_DEC, 64'h5a5a_5a5a_5a5a_5a5a);

    // Random: small key pool with near-miss keys so the table fills and drains
    for (int i = 0; i < POOL_N / 2; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = POOL_N / 2; i < POOL_N; i++)
      key_pool[i] = key_pool[i - POOL_N / 2] ^ (64'h1 << $urandom_range(KEY_FW - 1));
    key_pool[0] = '0;
    key_pool[1] = {KEY_FW{1'b1}};
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin cur_idle = 0;  cur_stall = 0;  end
        1: begin cur_idle = 45; cur_stall = 0;  end
        2: begin cur_idle = 0;  cur_stall = 45; end
        default: begin cur_idle = 7; cur_stall = 7; end
      endcase
      for (int n = 0; n < PHASE_OPS; n++) begin
        // alternate insert-heavy and remove-heavy stretches
        ins_pct = ((n / 40) % 2 == 0) ? 75 : 25;
        if ($urandom_range(99) < 10) k = {$urandom, $urandom};
        else k = key_pool[$urandom_range(POOL_N - 1)];
        queue_op(($urandom_range(99) < ins_pct) ? MODE_INC : MODE_DEC, k, n == 0);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (op_q.size() != 0 || req_ch.valid || tally_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
    if (tally_q.size() != 0) flag_error("results still outstanding at end of run");

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
rtl/kct_pkg.sv
rtl/kct_req_if.sv
rtl/kct_rsp_if.sv
rtl/keyed_count_table_unit.sv
bench/tb.sv
